// ----- rtl/core/alist_pkg.sv -----
package alist_pkg;

    localparam int unsigned DEF_DEPTH = 16;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned MODE_W    = 3;
    localparam int unsigned POS_W     = 5;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned CNT_W     = 5;
    localparam int unsigned STAT_W    = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ   = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_REMOVE = 3'd2,
        MODE_MODIFY = 3'd3,
        MODE_SEARCH = 3'd4
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_WRITE
    } t_cell_op;

    typedef struct packed {
        t_cell_op            op;
        logic [WORD_W-1:0]   value;
    } t_cell_cmd;

endpackage

// ----- rtl/core/alist_cell.sv -----
module alist_cell #(
    parameter int unsigned PW  = 5,
    parameter int unsigned IDX = 0
) (
    input  logic                       i_clk,
    input  alist_pkg::t_cell_cmd       i_cmd,
    input  logic [PW-1:0]              i_pos,
    input  logic [alist_pkg::WORD_W-1:0] i_left,
    input  logic [alist_pkg::WORD_W-1:0] i_right,
    output logic [alist_pkg::WORD_W-1:0] o_data,
    output logic                       o_match
);
    import alist_pkg::*;

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [WORD_W-1:0] r_data;
    logic [WORD_W-1:0] n_data;
    logic              r_match;

    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            CELL_INSERT: begin
                if (MY_IDX > i_pos) begin
                    n_data = i_left;
                end else if (MY_IDX == i_pos) begin
                    n_data = i_cmd.value;
                end
            end
            CELL_REMOVE: begin
                if (MY_IDX >= i_pos) begin
                    n_data = i_right;
                end
            end
            CELL_WRITE: begin
                if (MY_IDX == i_pos) begin
                    n_data = i_cmd.value;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= (r_data == i_cmd.value);
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

// ----- rtl/core/alist_prio.sv -----
module alist_prio #(
    parameter int unsigned DEPTH = alist_pkg::DEF_DEPTH
) (
    input  logic [DEPTH-1:0]               i_mask,
    output logic                           o_found,
    output logic [$clog2(DEPTH)-1:0]       o_idx
);
    import alist_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);

    always_comb begin
        o_idx = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (i_mask[k]) begin
                o_idx = AW'(k);
            end
        end
    end

    assign o_found = |i_mask;

endmodule

// ----- rtl/core/array_list_insert_remove_search_unit.sv -----
// Channel   Direction  Handshake          Payload
// request   in         i_valid / o_ready  i_mode, i_position, i_value
// result    out        o_valid / i_ready  o_read_value, o_found_index, o_item_count, o_status
//
// Each request passes through three states: accept, one in which every cell shifts, writes
// or compares in parallel, and one for the first-match encoder, which waits for the output
// register to be free. A new request is accepted only after the previous one has finished.
// A pending result may wait in the output register while the next request is accepted.
// Reset clears the count and the control state; the cells need no reset.
module array_list_insert_remove_search_unit #(
    parameter int unsigned DEPTH = alist_pkg::DEF_DEPTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [alist_pkg::MODE_W-1:0]           i_mode,
    input  logic [alist_pkg::POS_W-1:0]            i_position,
    input  logic signed [alist_pkg::WORD_W-1:0]    i_value,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [alist_pkg::WORD_W-1:0]    o_read_value,
    output logic [alist_pkg::IDX_W-1:0]            o_found_index,
    output logic [alist_pkg::CNT_W-1:0]            o_item_count,
    output logic [alist_pkg::STAT_W-1:0]           o_status
);
    import alist_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state              r_state;
    t_mode               r_mode;
    logic [PW-1:0]       r_pos;
    logic [WORD_W-1:0]   r_val;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    t_status             r_status;
    t_status             n_status;
    logic [WORD_W-1:0]   r_rd;
    logic [WORD_W-1:0]   n_rd;
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_rd;
    logic [IDX_W-1:0]    r_out_idx;
    logic [CNT_W-1:0]    r_out_cnt;
    t_status             r_out_status;

    t_cell_cmd           w_cmd;
    logic [WORD_W-1:0]   w_data  [DEPTH];
    logic [WORD_W-1:0]   w_left  [DEPTH];
    logic [WORD_W-1:0]   w_right [DEPTH];
    logic [DEPTH-1:0]    w_match;
    logic [DEPTH-1:0]    w_mask;
    logic                w_found;
    logic [AW-1:0]       w_idx;
    logic                w_in_range;
    logic                w_load;

    assign o_ready = (r_state == S_IDLE);
    assign w_in_range = (r_pos < PW'(r_count));
    assign w_load = (r_state == S_DONE) && (!r_out_valid || i_ready);

    always_comb begin
        w_cmd.op    = CELL_HOLD;
        w_cmd.value = r_val;
        n_count     = r_count;
        n_status    = ST_OK;
        n_rd        = '0;
        if (r_state == S_EXEC) begin
            unique case (r_mode)
                MODE_READ: begin
                    if (w_in_range) begin
                        n_rd = w_data[r_pos[AW-1:0]];
                    end else begin
                        n_status = ST_RANGE;
                    end
                end
                MODE_INSERT: begin
                    if (r_count >= FULL_CNT) begin
                        n_status = ST_FULL;
                    end else if (r_pos > PW'(r_count)) begin
                        n_status = ST_RANGE;
                    end else begin
                        w_cmd.op = CELL_INSERT;
                        n_count  = r_count + CW'(1);
                    end
                end
                MODE_REMOVE: begin
                    if (w_in_range) begin
                        w_cmd.op = CELL_REMOVE;
                        n_count  = r_count - CW'(1);
                    end else begin
                        n_status = ST_RANGE;
                    end
                end
                MODE_MODIFY: begin
                    if (w_in_range) begin
                        w_cmd.op = CELL_WRITE;
                    end else begin
                        n_status = ST_RANGE;
                    end
                end
                default: n_status = ST_OK;
            endcase
        end
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_first
            assign w_left[k] = r_val;
        end else begin : g_mid_l
            assign w_left[k] = w_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign w_right[k] = r_val;
        end else begin : g_mid_r
            assign w_right[k] = w_data[k+1];
        end
        assign w_mask[k] = w_match[k] && (CW'(k) < r_count);

        alist_cell #(
            .PW  (PW),
            .IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_pos   (r_pos),
            .i_left  (w_left[k]),
            .i_right (w_right[k]),
            .o_data  (w_data[k]),
            .o_match (w_match[k])
        );
    end

    alist_prio #(
        .DEPTH (DEPTH)
    ) u_prio (
        .i_mask  (w_mask),
        .o_found (w_found),
        .o_idx   (w_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode  <= t_mode'(i_mode);
                        r_pos   <= PW'(i_position);
                        r_val   <= i_value;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_count  <= n_count;
                    r_status <= n_status;
                    r_rd     <= n_rd;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (w_load) begin
                        r_out_rd    <= r_rd;
                        r_out_cnt   <= CNT_W'(r_count);
                        if (r_mode == MODE_SEARCH) begin
                            r_out_status <= w_found ? ST_OK : ST_MISS;
                            r_out_idx    <= w_found ? IDX_W'(w_idx) : '0;
                        end else begin
                            r_out_status <= r_status;
                            r_out_idx    <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_value  = r_out_rd;
    assign o_found_index = r_out_idx;
    assign o_item_count  = r_out_cnt;
    assign o_status      = r_out_status;

endmodule
